FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: label");

`endif

FILE: rtl/rbpb_pkg.sv
// ----------------------------------------------------------------------------
// rbpb_pkg
// Types and constants of the rotated bitmap pixel blit.
// ----------------------------------------------------------------------------
package rbpb_pkg;

   localparam int COORD_BITS  = 11;
   localparam int COLUMN_BITS = 8;
   localparam int LANES       = 8;
   localparam int SEL_BITS    = $clog2(LANES);
   localparam int X_BITS      = COLUMN_BITS + SEL_BITS;
   localparam int CMP_BITS    = (COORD_BITS > X_BITS) ? COORD_BITS : X_BITS;
   localparam int INDEX_BITS  = 3;

   localparam logic [INDEX_BITS-1:0] REG_PAGE_WIDTH     = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_PAGE_HEIGHT    = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_CANVAS_WIDTH   = 3'd2;
   localparam logic [INDEX_BITS-1:0] REG_CANVAS_HEIGHT  = 3'd3;
   localparam logic [INDEX_BITS-1:0] REG_TURN_CLOCKWISE = 3'd4;

   typedef struct packed {
      logic [COORD_BITS-1:0]  page_row;
      logic [COLUMN_BITS-1:0] byte_column;
      logic [LANES-1:0]       pixel_byte;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] dest_x;
      logic [COORD_BITS-1:0] dest_y;
      logic                  last;
      logic                  fit_error;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] page_width;
      logic [COORD_BITS-1:0] top;
      logic                  clockwise;
   } lane_cfg_type;

   typedef struct packed {
      logic [LANES-1:0]      mask;
      logic [COORD_BITS-1:0] dest_x;
      logic                  fit_error;
   } load_type;

endpackage

FILE: rtl/rotated_bitmap_pixel_blit_core.sv
// ----------------------------------------------------------------------------
// rotated_bitmap_pixel_blit_core
// Maps black pixels of a 1 bpp page byte onto a quarter-turned, centred canvas.
// ----------------------------------------------------------------------------
// Each accepted byte is decoded by eight pixel lanes in its transfer cycle, and
// its hits are then issued one per cycle while the output is not stalled, from a
// single result register, lowest page x first. A byte has at most eight results;
// a byte with no results leaves the block ready for the next byte. The next byte
// is otherwise taken in the cycle its predecessor's final result moves into the
// result register.
module rotated_bitmap_pixel_blit_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  rbpb_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output rbpb_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [rbpb_pkg::INDEX_BITS-1:0]       csr_index,
   input  logic [rbpb_pkg::COORD_BITS-1:0]       csr_wdata
);

   localparam int CB = rbpb_pkg::COORD_BITS;
   localparam int LN = rbpb_pkg::LANES;

   logic [CB-1:0] page_width_ff;
   logic [CB-1:0] page_height_ff;
   logic [CB-1:0] canvas_width_ff;
   logic [CB-1:0] canvas_height_ff;
   logic          clockwise_ff;

   logic                   fit_error;
   logic                   row_ok;
   logic [CB-1:0]          left;
   logic [CB-1:0]          dest_x;
   logic [LN-1:0]          lane_hit;
   logic [CB-1:0]          lane_y [LN];
   rbpb_pkg::lane_cfg_type lane_cfg;
   rbpb_pkg::load_type     load;
   logic                   load_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_width_ff    <= '0;
         page_height_ff   <= '0;
         canvas_width_ff  <= '0;
         canvas_height_ff <= '0;
         clockwise_ff     <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rbpb_pkg::REG_PAGE_WIDTH:     page_width_ff    <= csr_wdata;
            rbpb_pkg::REG_PAGE_HEIGHT:    page_height_ff   <= csr_wdata;
            rbpb_pkg::REG_CANVAS_WIDTH:   canvas_width_ff  <= csr_wdata;
            rbpb_pkg::REG_CANVAS_HEIGHT:  canvas_height_ff <= csr_wdata;
            rbpb_pkg::REG_TURN_CLOCKWISE: clockwise_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign fit_error = (page_width_ff == '0) || (page_height_ff == '0) ||
                      (page_height_ff > canvas_width_ff) ||
                      (page_width_ff > canvas_height_ff);

   assign left               = (canvas_width_ff - page_height_ff) >> 1;
   assign lane_cfg.page_width = page_width_ff;
   assign lane_cfg.top       = (canvas_height_ff - page_width_ff) >> 1;
   assign lane_cfg.clockwise = clockwise_ff;
   assign row_ok             = (req_data.page_row < page_height_ff);

   always_comb begin
      if (clockwise_ff) begin
         dest_x = left + page_height_ff - CB'(1) - req_data.page_row;
      end else begin
         dest_x = left + req_data.page_row;
      end
   end

   for (genvar b = 0; b < LN; b++) begin : g_lane
      rbpb_lane #(
         .LANE (b)
      ) u_lane (
         .cfg         (lane_cfg),
         .byte_column (req_data.byte_column),
         .pixel       (req_data.pixel_byte[LN-1-b]),
         .hit         (lane_hit[b]),
         .dest_y      (lane_y[b])
      );
   end

   always_comb begin
      load.dest_x    = dest_x;
      load.fit_error = fit_error;
      if (fit_error) begin
         load.mask = LN'(1);
      end else if (row_ok) begin
         load.mask = lane_hit;
      end else begin
         load.mask = '0;
      end
   end

   assign load_valid = req_valid && req_ready;

   rbpb_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load       (load),
      .load_y     (lane_y),
      .load_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: rtl/rbpb_lane.sv
// ----------------------------------------------------------------------------
// rbpb_lane
// One pixel lane: decides whether its bit lands on the page and maps its y.
// ----------------------------------------------------------------------------
module rbpb_lane #(
   parameter int LANE = 0
) (
   input  rbpb_pkg::lane_cfg_type                 cfg,
   input  logic [rbpb_pkg::COLUMN_BITS-1:0]       byte_column,
   input  logic                                   pixel,
   output logic                                   hit,
   output logic [rbpb_pkg::COORD_BITS-1:0]        dest_y
);

   localparam int CB = rbpb_pkg::COORD_BITS;
   localparam int XB = rbpb_pkg::X_BITS;
   localparam int MB = rbpb_pkg::CMP_BITS;
   localparam int SB = rbpb_pkg::SEL_BITS;

   logic [XB-1:0] page_x;
   logic [CB-1:0] x_low;

   assign page_x = {byte_column, SB'(LANE)};
   assign x_low  = CB'(page_x);
   assign hit    = pixel && (MB'(page_x) < MB'(cfg.page_width));

   always_comb begin
      if (cfg.clockwise) begin
         dest_y = cfg.top + x_low;
      end else begin
         dest_y = cfg.top + cfg.page_width - CB'(1) - x_low;
      end
   end

endmodule

FILE: rtl/rbpb_merge.sv
// ----------------------------------------------------------------------------
// rbpb_merge
// Holds the lane hits of one byte and issues them in page x order, one per
// transfer, through the result register.
// ----------------------------------------------------------------------------
module rbpb_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load_valid,
   input  rbpb_pkg::load_type                  load,
   input  logic [rbpb_pkg::COORD_BITS-1:0]     load_y [rbpb_pkg::LANES],
   output logic                                load_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rbpb_pkg::rsp_type                   rsp_data
);

   localparam int CB = rbpb_pkg::COORD_BITS;
   localparam int LN = rbpb_pkg::LANES;
   localparam int SB = rbpb_pkg::SEL_BITS;

   logic [LN-1:0]     mask_ff, mask_in;
   logic [CB-1:0]     x_ff;
   logic [CB-1:0]     y_ff [LN];
   logic              err_ff;
   logic              out_valid_ff, out_valid_in;
   rbpb_pkg::rsp_type out_data_ff, out_data_in;

   logic              pop;
   logic [SB-1:0]     sel;
   logic [LN-1:0]     rest;
   logic [LN-1:0]     remaining;

   always_comb begin
      sel = '0;
      for (int i = LN - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = SB'(i);
         end
      end
   end

   assign pop        = (mask_ff != '0) && (!out_valid_ff || rsp_ready);
   assign rest       = mask_ff & (mask_ff - LN'(1));
   assign remaining  = pop ? rest : mask_ff;
   assign load_ready = (remaining == '0);
   assign mask_in    = load_valid ? load.mask : remaining;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (pop) begin
         out_valid_in          = 1'b1;
         out_data_in.dest_x    = err_ff ? '0 : x_ff;
         out_data_in.dest_y    = err_ff ? '0 : y_ff[sel];
         out_data_in.last      = (rest == '0);
         out_data_in.fit_error = err_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      if (load_valid) begin
         x_ff   <= load.dest_x;
         err_ff <= load.fit_error;
         y_ff   <= load_y;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: rtl/rbpb_checker.sv
// ----------------------------------------------------------------------------
// rbpb_checker
// Port-level checks of the rotated bitmap pixel blit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbpb_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_ready,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  rbpb_pkg::rsp_type                     rsp_data
);

   logic zero_coords;

   assign zero_coords = (rsp_data.dest_x == '0) && (rsp_data.dest_y == '0);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   `ASSERT_IMPLY(a_err_last, clock, reset, rsp_valid && rsp_data.fit_error, rsp_data.last)

   `ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid && rsp_data.fit_error, zero_coords)

   `ASSERT_IMPLY(a_busy_mid_byte, clock, reset, rsp_valid && !rsp_data.last && !rsp_ready, !req_ready)

endmodule

bind rotated_bitmap_pixel_blit_core rbpb_checker u_rbpb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
